// File: hw/rtl/i2cs_pkg.sv
// Shared types, constants and the probe step decode of the I2C address scanner.
package i2cs_pkg;

    localparam int ADDR_W          = 7;
    localparam int HOLD_W          = 16;
    localparam int STEP_W          = 6;
    localparam int COUNT_OUT_W     = 5;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 16;
    localparam int DEFAULT_MAX_FOUND = 16;

    localparam logic [ADDR_W-1:0] ADDR_LOW_RESET  = 7'h08;
    localparam logic [ADDR_W-1:0] ADDR_HIGH_RESET = 7'h77;
    localparam logic [HOLD_W-1:0] HOLD_RESET      = 16'd750;

    localparam logic [CFG_IDX_W-1:0] CFG_ADDR_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ADDR_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_TICKS = 2'd2;

    localparam logic REQ_TICK  = 1'b0;
    localparam logic REQ_START = 1'b1;

    localparam logic [STEP_W-1:0] STEP_FIRST      = 6'd0;
    localparam logic [STEP_W-1:0] STEP_ACK_SAMPLE = 6'd29;
    localparam logic [STEP_W-1:0] STEP_LAST       = 6'd33;

    typedef struct packed {
        logic [ADDR_W-1:0] addr_low;
        logic [ADDR_W-1:0] addr_high;
        logic [HOLD_W-1:0] half_period_ticks;
    } cfg_t;

    typedef struct packed {
        logic scl_set;
        logic scl_val;
        logic sda_set;
        logic sda_val;
    } drive_t;

    // Line change made on entry to a probe step.
    function automatic drive_t step_drive(input logic [STEP_W-1:0] s,
                                          input logic [ADDR_W-1:0] addr);
        drive_t d;
        d = '0;
        case (s)
            6'd0:  begin d.sda_set = 1'b1; d.sda_val = 1'b1;    end
            6'd1:  begin d.scl_set = 1'b1; d.scl_val = 1'b1;    end
            6'd2:  begin d.sda_set = 1'b1; d.sda_val = 1'b0;    end
            6'd3:  begin d.scl_set = 1'b1; d.scl_val = 1'b0;    end
            6'd4:  begin d.sda_set = 1'b1; d.sda_val = addr[6]; end
            6'd7:  begin d.sda_set = 1'b1; d.sda_val = addr[5]; end
            6'd10: begin d.sda_set = 1'b1; d.sda_val = addr[4]; end
            6'd13: begin d.sda_set = 1'b1; d.sda_val = addr[3]; end
            6'd16: begin d.sda_set = 1'b1; d.sda_val = addr[2]; end
            6'd19: begin d.sda_set = 1'b1; d.sda_val = addr[1]; end
            6'd22: begin d.sda_set = 1'b1; d.sda_val = addr[0]; end
            6'd25: begin d.sda_set = 1'b1; d.sda_val = 1'b0;    end
            6'd5, 6'd8, 6'd11, 6'd14, 6'd17, 6'd20, 6'd23, 6'd26, 6'd29, 6'd32:
                begin d.scl_set = 1'b1; d.scl_val = 1'b1; end
            6'd6, 6'd9, 6'd12, 6'd15, 6'd18, 6'd21, 6'd24, 6'd27, 6'd30:
                begin d.scl_set = 1'b1; d.scl_val = 1'b0; end
            6'd28: begin d.sda_set = 1'b1; d.sda_val = 1'b1;    end
            6'd31: begin d.sda_set = 1'b1; d.sda_val = 1'b0;    end
            default: begin d.sda_set = 1'b1; d.sda_val = 1'b1;  end
        endcase
        return d;
    endfunction

endpackage

// File: hw/rtl/i2cs_req_if.sv
// Input item channel: request type and sampled SDA level.
interface i2cs_req_if;
    logic valid;
    logic ready;
    logic req_type;
    logic sda_in;

    modport source (output valid, output req_type, output sda_in, input ready);
    modport sink   (input valid, input req_type, input sda_in, output ready);
endinterface

// File: hw/rtl/i2cs_res_if.sv
// Result item channel: bus levels, scan status and found addresses.
interface i2cs_res_if import i2cs_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic                   scl_level;
    logic                   sda_level;
    logic                   busy_res;
    logic                   found_valid;
    logic [ADDR_W-1:0]      found_addr;
    logic [COUNT_OUT_W-1:0] ack_count;
    logic                   scan_done;

    modport source (output valid, output scl_level, output sda_level, output busy_res,
                    output found_valid, output found_addr, output ack_count,
                    output scan_done, input ready);
    modport sink   (input valid, input scl_level, input sda_level, input busy_res,
                    input found_valid, input found_addr, input ack_count,
                    input scan_done, output ready);
endinterface

// File: hw/rtl/i2cs_cfg_if.sv
// Configuration write channel: register index and write data.
interface i2cs_cfg_if import i2cs_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/i2cs_cfg_regs.sv
// Configuration registers of the I2C address scanner.
module i2cs_cfg_regs import i2cs_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    i2cs_cfg_if.sink    cfg,
    output cfg_t        regs
);

    cfg_t regs_reg;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.addr_low          <= ADDR_LOW_RESET;
            regs_reg.addr_high         <= ADDR_HIGH_RESET;
            regs_reg.half_period_ticks <= HOLD_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_ADDR_LOW:   regs_reg.addr_low          <= cfg.data[ADDR_W-1:0];
                CFG_ADDR_HIGH:  regs_reg.addr_high         <= cfg.data[ADDR_W-1:0];
                CFG_HALF_TICKS: regs_reg.half_period_ticks <= cfg.data[HOLD_W-1:0];
                default:        regs_reg <= regs_reg;
            endcase
        end
    end

endmodule

// File: hw/rtl/i2cs_core.sv
// Scan sequencer state and registered result stage of the I2C address scanner.
module i2cs_core import i2cs_pkg::*; #(
    parameter int MAX_FOUND = DEFAULT_MAX_FOUND
) (
    input  logic     clk,
    input  logic     rst_n,
    input  cfg_t     regs,
    i2cs_req_if.sink req,
    i2cs_res_if.source res
);

    localparam int CNT_W = $clog2(MAX_FOUND + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FOUND);

    logic              scanning_reg, scanning_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [HOLD_W-1:0] hold_reg, hold_next;
    logic              scl_reg, scl_next;
    logic              sda_reg, sda_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    logic              out_valid_reg;
    logic              found_valid_next, done_next;
    logic [ADDR_W-1:0] found_addr_next;
    logic              scl_out_reg, sda_out_reg, busy_out_reg;
    logic              found_valid_reg, done_reg;
    logic [ADDR_W-1:0] found_addr_reg;
    logic [CNT_W-1:0]  count_out_reg;

    logic              accept;
    logic [HOLD_W-1:0] hold_limit;
    logic [HOLD_W:0]   hold_inc;
    logic [STEP_W-1:0] step_enter;
    logic              apply_step;
    drive_t            drv;

    assign req.ready  = !out_valid_reg || res.ready;
    assign accept     = req.valid && req.ready;
    assign hold_limit = (regs.half_period_ticks == '0) ? HOLD_W'(1) : regs.half_period_ticks;
    assign hold_inc   = {1'b0, hold_reg} + (HOLD_W+1)'(1);
    assign drv        = step_drive(step_enter, addr_next);
    assign scl_next   = (apply_step && drv.scl_set) ? drv.scl_val : scl_reg;
    assign sda_next   = (apply_step && drv.sda_set) ? drv.sda_val : sda_reg;

    always_comb
    begin
        scanning_next    = scanning_reg;
        addr_next        = addr_reg;
        step_next        = step_reg;
        hold_next        = hold_reg;
        count_next       = count_reg;
        found_valid_next = 1'b0;
        found_addr_next  = '0;
        done_next        = 1'b0;
        step_enter       = STEP_FIRST;
        apply_step       = 1'b0;

        if (req.req_type == REQ_START)
        begin
            count_next = '0;
            hold_next  = '0;
            step_next  = STEP_FIRST;
            addr_next  = regs.addr_low;
            if (regs.addr_low > regs.addr_high)
            begin
                scanning_next = 1'b0;
                done_next     = 1'b1;
            end
            else
            begin
                scanning_next = 1'b1;
                apply_step    = 1'b1;
            end
        end
        else if (scanning_reg)
        begin
            hold_next = hold_inc[HOLD_W-1:0];
            if (hold_inc >= {1'b0, hold_limit})
            begin
                hold_next = '0;
                if (step_reg == STEP_ACK_SAMPLE && !req.sda_in)
                begin
                    found_valid_next = 1'b1;
                    found_addr_next  = addr_reg;
                    if (count_reg < CNT_MAX)
                        count_next = count_reg + CNT_W'(1);
                end
                if (step_reg >= STEP_LAST)
                begin
                    step_next = STEP_FIRST;
                    if (addr_reg >= regs.addr_high)
                    begin
                        scanning_next = 1'b0;
                        done_next     = 1'b1;
                    end
                    else
                    begin
                        addr_next  = addr_reg + ADDR_W'(1);
                        apply_step = 1'b1;
                    end
                end
                else
                begin
                    step_next  = step_reg + STEP_W'(1);
                    step_enter = step_reg + STEP_W'(1);
                    apply_step = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scanning_reg  <= 1'b0;
            addr_reg      <= '0;
            step_reg      <= '0;
            hold_reg      <= '0;
            scl_reg       <= 1'b1;
            sda_reg       <= 1'b1;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                scanning_reg <= scanning_next;
                addr_reg     <= addr_next;
                step_reg     <= step_next;
                hold_reg     <= hold_next;
                scl_reg      <= scl_next;
                sda_reg      <= sda_next;
                count_reg    <= count_next;
            end
            if (accept)
                out_valid_reg <= 1'b1;
            else if (res.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            scl_out_reg     <= scl_next;
            sda_out_reg     <= sda_next;
            busy_out_reg    <= scanning_next;
            found_valid_reg <= found_valid_next;
            found_addr_reg  <= found_addr_next;
            count_out_reg   <= count_next;
            done_reg        <= done_next;
        end
    end

    assign res.valid       = out_valid_reg;
    assign res.scl_level   = scl_out_reg;
    assign res.sda_level   = sda_out_reg;
    assign res.busy_res    = busy_out_reg;
    assign res.found_valid = found_valid_reg;
    assign res.found_addr  = found_addr_reg;
    assign res.ack_count   = COUNT_OUT_W'(count_out_reg);
    assign res.scan_done   = done_reg;

endmodule

// File: hw/rtl/i2c_address_scanner.sv
// I2C address scanner: drives SCL and SDA probe levels and reports acknowledged addresses.
//
// Channels: req takes one item per tick of bus time (req_type 0) or a scan start
// (req_type 1), with the sampled SDA level. res returns exactly one item per
// req item: the SCL and SDA levels to drive, busy, a found address pulse, the
// saturating found count and a done pulse. cfg writes addr_low (index 0),
// addr_high (index 1) and half_period_ticks (index 2); it is always ready. It is to be
// written only while no scan item is in flight; the block itself does not enforce this.
// Latency: a result appears in the cycle after its req item is taken.
// Throughput: one item per cycle while res takes each result; the sequencer state
// and the result register both update in the accepting cycle.
// Stall: while res is held, one result waits in the output register and req
// stays ready only if that result is taken in the same cycle.
// Reset: scanner idle, both lines released high, count zero, registers at
// addr_low 0x08, addr_high 0x77, half_period_ticks 750; no result pending.
module i2c_address_scanner import i2cs_pkg::*; #(
    parameter int MAX_FOUND = DEFAULT_MAX_FOUND
) (
    input  logic       clk,
    input  logic       rst_n,
    i2cs_req_if.sink   req,
    i2cs_res_if.source res,
    i2cs_cfg_if.sink   cfg
);

    cfg_t regs;

    i2cs_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    i2cs_core #(
        .MAX_FOUND (MAX_FOUND)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .regs  (regs),
        .req   (req),
        .res   (res)
    );

endmodule
